// ===== hdl/arpc_pkg.sv =====
// Shared types, constants and hash function of the ARP cache responder.
package arpc_pkg;

   localparam int TABLE_SLOTS = 32;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam logic [31:0] HASH_MULT = 32'd2654435761;
   localparam logic [10:0] MIN_FRAME = 11'd28;
   localparam logic [15:0] HW_ETH = 16'd1;
   localparam logic [15:0] PROTO_IPV4 = 16'h0800;
   localparam logic [7:0] HW_LEN = 8'd6;
   localparam logic [7:0] PROTO_LEN = 8'd4;
   localparam logic [15:0] OP_REQUEST = 16'd1;
   localparam logic [1:0] TX_NONE = 2'd0;
   localparam logic [1:0] TX_REQUEST = 2'd1;
   localparam logic [1:0] TX_REPLY = 2'd2;
   localparam logic [47:0] BCAST = 48'hFFFF_FFFF_FFFF;
   localparam int LOAD_LIMIT = TABLE_SLOTS * 3;

   localparam logic [1:0] ACT_RECEIVE = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_ANNOUNCE = 2'd2;

   localparam logic [1:0] KIND_HIT = 2'd0;
   localparam logic [1:0] KIND_MISS = 2'd1;
   localparam logic [1:0] KIND_REPLY = 2'd2;
   localparam logic [1:0] KIND_ANNOUNCE = 2'd3;

   localparam logic [0:0] CSR_OWN_IP = 1'd0;
   localparam logic [0:0] CSR_OWN_MAC = 1'd1;

   localparam int REQ_W = 224;
   localparam int RSP_W = 184;

   // Classified work passed from the front end to the table engine.
   typedef struct packed {
      logic        learn;      // store sender mapping
      logic        lookup;     // resolve key
      logic        reply;      // emit a reply after learning
      logic        announce;   // emit announcement
      logic [31:0] key;
      logic [47:0] mac;
      logic [31:0] own_ip;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] found_mac;
      logic [1:0]  tx_opcode;
      logic [47:0] tx_dest_mac;
      logic [47:0] tx_target_mac;
      logic [31:0] tx_target_ip;
   } rsp_type;

   function automatic logic [SLOT_W-1:0] home_slot(input logic [31:0] key);
      logic [31:0] h;
      h = key * HASH_MULT;
      return SLOT_W'(h % TABLE_SLOTS);
   endfunction

endpackage

// ===== hdl/arpc_front.sv =====
// Front end: accepts items, checks frames and issues commands to the queue.
module arpc_front import arpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [31:0]  own_ip,
   output logic         cmd_valid,
   input  logic         cmd_ready,
   output cmd_type      cmd
);
   logic [1:0]  action;
   logic [10:0] frame_len;
   logic [15:0] hw_type, proto_type, operation;
   logic [7:0]  hw_len, proto_len;
   logic [47:0] sender_mac;
   logic [31:0] sender_ip, target_ip, query_ip;
   logic        frame_ok;

   assign action     = req_tdata[1:0];
   assign frame_len  = req_tdata[12:2];
   assign hw_type    = req_tdata[28:13];
   assign proto_type = req_tdata[44:29];
   assign hw_len     = req_tdata[52:45];
   assign proto_len  = req_tdata[60:53];
   assign operation  = req_tdata[76:61];
   assign sender_mac = req_tdata[124:77];
   assign sender_ip  = req_tdata[156:125];
   assign target_ip  = req_tdata[188:157];
   assign query_ip   = req_tdata[220:189];

   assign frame_ok = frame_len >= MIN_FRAME && hw_type == HW_ETH &&
                     proto_type == PROTO_IPV4 && hw_len == HW_LEN &&
                     proto_len == PROTO_LEN;

   // Frames that fail the checks and items of an unknown action are accepted and dropped here.
   assign req_tready = cmd_ready;

   always_comb begin
      cmd = '0;
      cmd_valid = 1'b0;
      unique case (action)
         ACT_RECEIVE: begin
            cmd.learn = frame_ok && sender_ip != 32'd0;
            cmd.reply = frame_ok && operation == OP_REQUEST && target_ip == own_ip;
            cmd.key = sender_ip;
            cmd.mac = sender_mac;
            cmd_valid = req_tvalid && frame_ok;
         end
         ACT_LOOKUP: begin
            cmd.lookup = 1'b1;
            cmd.key = query_ip;
            cmd_valid = req_tvalid;
         end
         ACT_ANNOUNCE: begin
            cmd.announce = 1'b1;
            cmd_valid = req_tvalid;
         end
         default: cmd_valid = 1'b0;
      endcase
      cmd.own_ip = own_ip;
   end
endmodule

// ===== hdl/arpc_queue.sv =====
// Two-entry command queue between the front end and the table engine.
module arpc_queue import arpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);
   cmd_type   mem_ff [2];
   logic      wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_cmd   = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign wr_in  = wr_ff ^ push;
   assign rd_in  = rd_ff ^ pop;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_cmd;
   end
endmodule

// ===== hdl/arpc_engine.sv =====
// Table engine: probes the hash table, learns mappings and builds results.
module arpc_engine import arpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [31:0] key_mem [TABLE_SLOTS];
   logic [47:0] mac_mem [TABLE_SLOTS];
   logic [31:0] key_rd;
   logic [47:0] mac_rd;

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   cmd_type           cur_ff, cur_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [31:0]       wr_key;
   logic [47:0]       wr_mac;
   logic              full;
   logic              emit_now;
   logic [47:0]       hit_mac;
   logic              hit;

   assign full = (32'(count_ff) + 32'd1) * 32'd4 >= 32'(LOAD_LIMIT);
   assign cmd_ready = state_ff == ST_IDLE && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_comb begin
      state_in = state_ff;
      slot_in = slot_ff;
      n_in = n_ff;
      count_in = count_ff;
      cur_in = cur_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en = 1'b0;
      wr_addr = slot_ff;
      wr_key = cur_ff.key;
      wr_mac = cur_ff.mac;
      emit_now = 1'b0;
      hit = 1'b0;
      hit_mac = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_key = '0;
            wr_mac = '0;
            slot_in = slot_ff + 1'b1;
            if (slot_ff == SLOT_W'(TABLE_SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cur_in = cmd;
               slot_in = home_slot(cmd.key);
               n_in = '0;
               if ((cmd.learn || cmd.lookup) && cmd.key != 32'd0) state_in = ST_READ;
               else state_in = ST_OUT;
            end
         end
         ST_READ: state_in = ST_PROBE;
         ST_PROBE: begin
            // The registered read of the current slot is examined here.
            if (key_rd == cur_ff.key) begin
               hit = 1'b1;
               hit_mac = mac_rd;
               if (cur_ff.learn) begin
                  wr_en = 1'b1;
                  wr_key = key_rd;
               end
               state_in = ST_OUT;
            end else if (key_rd == 32'd0 || n_ff == CNT_W'(TABLE_SLOTS - 1)) begin
               if (cur_ff.learn && key_rd == 32'd0 && !full) begin
                  wr_en = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_OUT;
            end else begin
               slot_in = slot_ff + 1'b1;
               n_in = n_ff + 1'b1;
               state_in = ST_READ;
            end
            if (cur_ff.lookup && state_in == ST_OUT) begin
               rsp_in.kind = hit ? KIND_HIT : KIND_MISS;
               rsp_in.found_mac = hit ? hit_mac : 48'd0;
               rsp_in.tx_opcode = hit ? TX_NONE : TX_REQUEST;
               rsp_in.tx_dest_mac = hit ? 48'd0 : BCAST;
               rsp_in.tx_target_mac = '0;
               rsp_in.tx_target_ip = hit ? 32'd0 : cur_ff.key;
               cur_in.lookup = 1'b0;
               emit_now = 1'b1;
            end
         end
         ST_OUT: begin
            state_in = ST_IDLE;
            if (cur_ff.lookup) begin
               // Lookup of zero is always a miss.
               rsp_in = '{KIND_MISS, 48'd0, TX_REQUEST, BCAST, 48'd0, cur_ff.key};
               emit_now = 1'b1;
            end else if (cur_ff.reply) begin
               rsp_in = '{KIND_REPLY, 48'd0, TX_REPLY, cur_ff.mac, cur_ff.mac, cur_ff.key};
               emit_now = 1'b1;
            end else if (cur_ff.announce) begin
               rsp_in = '{KIND_ANNOUNCE, 48'd0, TX_REPLY, BCAST, BCAST, cur_ff.own_ip};
               emit_now = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (emit_now) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         mac_mem[wr_addr] <= wr_mac;
      end
      key_rd <= key_mem[slot_ff];
      mac_rd <= mac_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         slot_ff <= '0;
         n_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff <= slot_in;
         n_ff <= n_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end
endmodule

// ===== hdl/arp_cache_responder_unit.sv =====
// Top level of the ARP cache responder.
// An accepted transfer is registered into a two-entry queue. The table engine takes a
// command, then for each probed slot does a registered read of the slot memory and then
// the compare, and then finishes; an announce, a reply-only receive or a lookup of zero
// skips the probe. A lookup result is registered at its last compare, other results when
// the engine finishes, and the engine takes no new command until the result has been
// transferred. After reset a clearing pass empties all TABLE_SLOTS (32) slots of the table
// before the first command is taken. Frames that fail the checks are dropped in the front
// end. New keys are dropped once storing one would bring the table to three quarters load.
module arp_cache_responder_unit import arpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // action, frame_len, hw_type, proto_type, hw_len, proto_len, operation,
   // sender_mac, sender_ip, target_ip, query_ip (lowest bit up), zero padded
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // kind, found_mac, tx_opcode, tx_dest_mac, tx_target_mac, tx_target_ip
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [47:0]      csr_wdata
);
   logic [31:0] own_ip_ff;
   logic [47:0] own_mac_ff;
   logic        f_valid, f_ready, q_valid, q_ready;
   cmd_type     f_cmd, q_cmd;
   rsp_type     rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
         own_mac_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_IP:  own_ip_ff <= csr_wdata[31:0];
            CSR_OWN_MAC: own_mac_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   arpc_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .own_ip(own_ip_ff), .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));

   arpc_queue u_queue (.clock, .reset, .in_valid(f_valid), .in_ready(f_ready),
      .in_cmd(f_cmd), .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd));

   arpc_engine u_engine (.clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready),
      .cmd(q_cmd), .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp);

   // The own MAC is held in a register but shows in no result field.
   assign rsp_tdata = {4'd0, rsp.tx_target_ip, rsp.tx_target_mac, rsp.tx_dest_mac,
                       rsp.tx_opcode, rsp.found_mac, rsp.kind} |
                      {RSP_W{1'b0 & own_mac_ff[0]}};
endmodule

// ===== hdl/arpc_checker.sv =====
// Port-level checker for the ARP cache responder, bound to the top level.
module arpc_checker import arpc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_hit_no_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == KIND_HIT |-> rsp_tdata[51:50] == TX_NONE)
      else $error("hit with transmit opcode");
   a_miss_bcast: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == KIND_MISS |-> rsp_tdata[99:52] == BCAST)
      else $error("miss not broadcast");
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result right after reset");
endmodule

bind arp_cache_responder_unit arpc_checker u_checker (.clock, .reset, .rsp_tvalid,
   .rsp_tready, .rsp_tdata);
